// ===== rtl/sspm_pkg.sv =====
package sspm_pkg;

  // Height switch codes
  localparam logic [1:0] SwIdle = 2'd0;
  localparam logic [1:0] SwUp   = 2'd1;
  localparam logic [1:0] SwDown = 2'd2;

  localparam int AngleLimit = 90;
  localparam int FlexFull   = 4095;
  localparam int PulseMid   = 1500;
  localparam int PulseMin   = 500;
  localparam int PulseMax   = 2500;

  // 52429 / 2^18 is 1/5 to within the exact range of a 14-bit dividend
  localparam int TiltRecip  = 52429;
  localparam int TiltShift  = 18;
  // 1000/90 = 100/9, and 364100 / 2^15 is 100/9 rounded up, exact for 8-bit magnitudes
  localparam int PulseRecip = 364100;
  localparam int PulseShift = 15;

  typedef struct packed {
    logic [1:0]         height_switch;
    logic [11:0]        flex_one;
    logic [11:0]        flex_two;
    logic [11:0]        flex_three;
    logic signed [15:0] roll_value;
    logic signed [15:0] pitch_value;
  } in_t;

  typedef struct packed {
    logic signed [7:0] waist_angle;
    logic signed [7:0] shoulder_angle;
    logic signed [7:0] elbow_angle;
    logic signed [7:0] roll_angle;
    logic signed [7:0] pitch_angle;
    logic signed [7:0] grip_angle;
    logic [11:0]       waist_pulse;
    logic [11:0]       shoulder_pulse;
    logic [11:0]       elbow_pulse;
    logic [11:0]       roll_pulse;
    logic [11:0]       pitch_pulse;
    logic [11:0]       grip_pulse;
  } out_t;

endpackage

// ===== rtl/sspm_waist.sv =====
module sspm_waist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        switch_i,
  output logic signed [7:0] position_o
);

  logic signed [7:0] position_q, position_d;

  always_comb begin
    position_d = position_q;
    if (step_i) begin
      if (switch_i == sspm_pkg::SwUp) begin
        if (position_q < 8'(sspm_pkg::AngleLimit)) position_d = position_q + 8'sd1;
      end else if (switch_i == sspm_pkg::SwDown) begin
        if (position_q > -8'(sspm_pkg::AngleLimit)) position_d = position_q - 8'sd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
    end else begin
      position_q <= position_d;
    end
  end

  assign position_o = position_q;

endmodule

// ===== rtl/sspm_flex_angle.sv =====
module sspm_flex_angle (
  input  logic [11:0]       flex_i,
  output logic signed [7:0] angle_o
);

  logic [18:0] scaled;
  logic [6:0]  quot_est;
  logic [12:0] rem;
  logic [6:0]  quot;

  always_comb begin
    scaled   = 19'(flex_i) * 19'(sspm_pkg::AngleLimit);
    // x/4096 undershoots x/4095 by at most one; the remainder tells
    quot_est = scaled[18:12];
    rem      = 13'(scaled[11:0]) + 13'(quot_est);
    quot     = (rem >= 13'(sspm_pkg::FlexFull)) ? quot_est + 7'd1 : quot_est;
    if (quot > 7'(sspm_pkg::AngleLimit)) quot = 7'(sspm_pkg::AngleLimit);
    angle_o  = $signed({1'b0, quot});
  end

endmodule

// ===== rtl/sspm_tilt_angle.sv =====
module sspm_tilt_angle (
  input  logic signed [15:0] value_i,
  output logic signed [7:0]  angle_o
);

  logic [16:0] wide;
  logic [16:0] mag;
  logic [14:0] quarter;
  logic [30:0] prod;
  logic [12:0] quot;
  logic [6:0]  sat;

  always_comb begin
    // divide the magnitude so the quotient truncates toward zero
    wide    = {value_i[15], value_i};
    mag     = value_i[15] ? 17'(-wide) : wide;
    quarter = mag[16:2];
    prod    = 31'(quarter) * 31'(sspm_pkg::TiltRecip);
    quot    = prod[30:sspm_pkg::TiltShift];
    sat     = (quot > 13'(sspm_pkg::AngleLimit)) ? 7'(sspm_pkg::AngleLimit) : quot[6:0];
    angle_o = value_i[15] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  end

endmodule

// ===== rtl/sspm_pulse.sv =====
module sspm_pulse (
  input  logic signed [7:0] angle_i,
  output logic [11:0]       pulse_o
);

  logic [7:0]  mag;
  logic [26:0] prod;
  logic [11:0] offset;
  logic [11:0] raw;

  always_comb begin
    mag    = angle_i[7] ? 8'(-angle_i) : 8'(angle_i);
    prod   = 27'(mag) * 27'(sspm_pkg::PulseRecip);
    offset = prod[26:sspm_pkg::PulseShift];
    raw    = angle_i[7] ? 12'(sspm_pkg::PulseMid) - offset
                        : 12'(sspm_pkg::PulseMid) + offset;
    if (raw < 12'(sspm_pkg::PulseMin)) begin
      pulse_o = 12'(sspm_pkg::PulseMin);
    end else if (raw > 12'(sspm_pkg::PulseMax)) begin
      pulse_o = 12'(sspm_pkg::PulseMax);
    end else begin
      pulse_o = raw;
    end
  end

endmodule

// ===== rtl/sensor_to_servo_pulse_mapper_unit.sv =====
// Channel   Direction  Handshake                   Payload
// input     in         in_valid_i / in_stall_o     in_data_i  (sspm_pkg::in_t)
// output    out        out_valid_o / out_stall_i   out_data_o (sspm_pkg::out_t)
//
// Input stage (item fields plus waist) and result register. A transfer moves
// through the input stage into the result register; one transfer per cycle while
// the output does not stall; the single angle and pulse pass between the stages sets
// the clock period. Reset clears both valid flags and sets the waist to zero.
// An output stall holds the result; the input stage still fills, so the
// input stalls only when both stages are full and the output is stalled.
module sensor_to_servo_pulse_mapper_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sspm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sspm_pkg::out_t out_data_o
);

  // Input stage
  logic          s1_valid_q, s1_valid_d;
  sspm_pkg::in_t s1_data_q;
  // Result stage
  logic           s2_valid_q, s2_valid_d;
  sspm_pkg::out_t s2_data_q, s2_data_d;

  logic in_take;
  logic s2_load;
  logic s1_free;

  logic signed [7:0] waist_cur;

  // Advance the input stage whenever the result register is empty or drains
  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign s1_free    = !s1_valid_q || s2_load;
  assign in_stall_o = !s1_free;
  assign in_take    = in_valid_i && s1_free;

  // Waist steps on each accepted transfer, so it always belongs to the
  // item held in the input stage
  sspm_waist u_waist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_take),
    .switch_i   (in_data_i.height_switch),
    .position_o (waist_cur)
  );

  // Angles
  sspm_flex_angle u_shoulder_angle (
    .flex_i  (s1_data_q.flex_three),
    .angle_o (s2_data_d.shoulder_angle)
  );

  sspm_flex_angle u_elbow_angle (
    .flex_i  (s1_data_q.flex_two),
    .angle_o (s2_data_d.elbow_angle)
  );

  sspm_flex_angle u_grip_angle (
    .flex_i  (s1_data_q.flex_one),
    .angle_o (s2_data_d.grip_angle)
  );

  sspm_tilt_angle u_roll_angle (
    .value_i (s1_data_q.roll_value),
    .angle_o (s2_data_d.roll_angle)
  );

  sspm_tilt_angle u_pitch_angle (
    .value_i (s1_data_q.pitch_value),
    .angle_o (s2_data_d.pitch_angle)
  );

  assign s2_data_d.waist_angle = waist_cur;

  // Pulse widths
  sspm_pulse u_waist_pulse (
    .angle_i (s2_data_d.waist_angle),
    .pulse_o (s2_data_d.waist_pulse)
  );

  sspm_pulse u_shoulder_pulse (
    .angle_i (s2_data_d.shoulder_angle),
    .pulse_o (s2_data_d.shoulder_pulse)
  );

  sspm_pulse u_elbow_pulse (
    .angle_i (s2_data_d.elbow_angle),
    .pulse_o (s2_data_d.elbow_pulse)
  );

  sspm_pulse u_roll_pulse (
    .angle_i (s2_data_d.roll_angle),
    .pulse_o (s2_data_d.roll_pulse)
  );

  sspm_pulse u_pitch_pulse (
    .angle_i (s2_data_d.pitch_angle),
    .pulse_o (s2_data_d.pitch_pulse)
  );

  sspm_pulse u_grip_pulse (
    .angle_i (s2_data_d.grip_angle),
    .pulse_o (s2_data_d.grip_pulse)
  );

  // Valid flags: fill on load, drop when the transfer leaves
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end

    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (s2_load) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule
